FILE: rtl/cmi_pkg.sv
// ----------------------------------------------------------------------------
// Chaotic map iterator package
// Shared constants, command codes and the control/status structs that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package cmi_pkg;

  localparam int PosWidth  = 32;
  localparam int PosFrac   = PosWidth - 3;
  localparam int ParFrac   = 28;
  localparam int LogFrac   = 30;
  localparam int Terms     = 20;

  localparam logic [31:0] POS_ONE  = 32'h2000_0000;
  localparam logic [31:0] POS_HALF = 32'h1000_0000;
  localparam logic [31:0] TWOPI_POS = 32'hC90F_DAA2;
  localparam logic [31:0] TWOPI_PAR = 32'h6487_ED51;
  localparam logic [63:0] LN2_Q62   = 64'h2C5C_85FD_F473_DE6B;
  localparam logic [63:0] Q62_ONE   = 64'h4000_0000_0000_0000;

  localparam logic [1:0] MAP_LOGISTIC = 2'd0;
  localparam logic [1:0] MAP_TENT     = 2'd1;
  localparam logic [1:0] MAP_POWER    = 2'd2;
  localparam logic [1:0] MAP_CIRCLE   = 2'd3;

  localparam logic [1:0] REG_MAP_KIND = 2'd0;
  localparam logic [1:0] REG_NONLIN   = 2'd1;
  localparam logic [1:0] REG_START    = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ZERO_CLIP,
    OP_ZERO,
    OP_MUL,
    OP_SAT,
    OP_NORM_INIT,
    OP_NORM_STEP,
    OP_LOG_STEP,
    OP_LOG_DONE,
    OP_EXP_SPLIT,
    OP_SERIES_INIT,
    OP_DIV,
    OP_TERM_ACC,
    OP_POW_DONE,
    OP_ROT_INIT,
    OP_ROT_RED,
    OP_ROT_SUM,
    OP_WRITE
  } op_t;

  typedef enum logic [2:0] {
    MS_X_CX,
    MS_R_PAR,
    MS_X_PAR,
    MS_CX_PAR,
    MS_M_M,
    MS_MAG_Z,
    MS_T_LN2,
    MS_TERM_U
  } msel_t;

  typedef struct packed {
    op_t   op;
    msel_t msel;
  } cmd_t;

  typedef struct packed {
    logic x_gt_one;
    logic x_lt_half;
    logic x_zero;
    logic norm_done;
    logic a_ge;
    logic term_last;
    logic mul_done;
    logic div_done;
  } status_t;

endpackage

FILE: rtl/cmi_datapath.sv
// ----------------------------------------------------------------------------
// Chaotic map iterator datapath
// Position register, shared multi-cycle multiplier, serial divider, log and
// series registers, and the output word register.
// ----------------------------------------------------------------------------
module cmi_datapath import cmi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        restart,
  input  logic [31:0] nonlinearity,
  input  logic [31:0] start_position,
  output status_t     sts,
  output logic [31:0] position,
  output logic        clipped
);

  logic [31:0] x;
  logic [31:0] pos_hold;
  logic [31:0] res;
  logic        clip;
  logic [31:0] cx;

  logic [63:0]  ma;
  logic [63:0]  mb;
  msel_t        ms;
  logic [127:0] acc;
  logic [2:0]   mph;
  logic         mbusy;
  logic         mdone;
  logic [63:0]  mres;
  logic [63:0]  op_a;
  logic [63:0]  op_b;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  prod;
  logic [127:0] pp;
  logic [127:0] accs;
  logic [63:0]  sat;

  logic [63:0] dq;
  logic [4:0]  drem;
  logic [5:0]  dcnt;
  logic        dbusy;
  logic        ddone;
  logic [5:0]  r2;
  logic        qbit;

  logic [63:0] m;
  logic [4:0]  p;
  logic [29:0] f;
  logic        neg;
  logic [35:0] mag;
  logic signed [10:0] ie;
  logic [29:0] fr;
  logic [63:0] u;
  logic [63:0] term;
  logic [63:0] sum;
  logic [4:0]  idx;
  logic [31:0] a;
  logic [31:0] rx;

  logic [4:0]  kk;
  logic [4:0]  pm;
  logic [8:0]  ival;
  logic [29:0] fval;
  logic signed [11:0] sh;
  logic [5:0]  sha;
  logic [63:0] shv;
  logic [28:0] frac;
  logic [32:0] rsum;

  assign cx = POS_ONE - x;

  always_comb begin
    case (cmd.msel)
      MS_X_CX: begin
        op_a = {32'b0, x};
        op_b = {32'b0, cx};
      end
      MS_R_PAR: begin
        op_a = mres;
        op_b = {32'b0, nonlinearity};
      end
      MS_X_PAR: begin
        op_a = {32'b0, x};
        op_b = {32'b0, nonlinearity};
      end
      MS_CX_PAR: begin
        op_a = {32'b0, cx};
        op_b = {32'b0, nonlinearity};
      end
      MS_M_M: begin
        op_a = m;
        op_b = m;
      end
      MS_MAG_Z: begin
        op_a = {28'b0, mag};
        op_b = {32'b0, nonlinearity};
      end
      MS_T_LN2: begin
        op_a = {2'b0, fr, 32'b0};
        op_b = LN2_Q62;
      end
      MS_TERM_U: begin
        op_a = term;
        op_b = u;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign pa   = mph[1] ? ma[63:32] : ma[31:0];
  assign pb   = mph[0] ? mb[63:32] : mb[31:0];
  assign prod = {32'b0, pa} * {32'b0, pb};
  assign pp   = {64'b0, prod} << {{1'b0, mph[1]} + {1'b0, mph[0]}, 5'b0};

  always_comb begin
    case (ms)
      MS_X_CX:                    accs = acc >> PosFrac;
      MS_M_M, MS_T_LN2, MS_TERM_U: accs = acc >> 62;
      default:                    accs = acc >> ParFrac;
    endcase
    sat = (accs[127:64] != '0) ? '1 : accs[63:0];
  end

  assign r2   = {drem, dq[63]};
  assign qbit = (r2 >= {1'b0, idx});

  assign kk   = 5'(PosFrac) - p;
  assign pm   = p - 5'(PosFrac);
  assign ival = mres[38:30];
  assign fval = mres[29:0];

  always_comb begin
    sh   = 12'sd33 - 12'(ie);
    sha  = sh[11] ? 6'(-sh) : sh[5:0];
    shv  = sh[11] ? (sum << sha) : (sum >> sha);
    frac = (sh >= 12'sd64 || sh <= -12'sd64) ? '0 : shv[28:0];
  end

  assign rsum = {1'b0, rx} + {a, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      x     <= '0;
      mbusy <= 1'b0;
      mdone <= 1'b0;
      dbusy <= 1'b0;
      ddone <= 1'b0;
    end else begin
      if (mbusy) begin
        if (mph == 3'd4) begin
          mres  <= sat;
          mdone <= 1'b1;
          mbusy <= 1'b0;
        end else begin
          acc <= acc + pp;
          mph <= mph + 3'd1;
        end
      end
      if (dbusy) begin
        dq   <= {dq[62:0], qbit};
        drem <= qbit ? 5'(r2 - {1'b0, idx}) : r2[4:0];
        dcnt <= dcnt + 6'd1;
        if (dcnt == 6'd63) begin
          dbusy <= 1'b0;
          ddone <= 1'b1;
        end
      end
      case (cmd.op)
        OP_LOAD: begin
          x        <= restart ? start_position : x;
          pos_hold <= restart ? start_position : x;
        end
        OP_ZERO_CLIP: begin
          res  <= '0;
          clip <= (nonlinearity != '0);
        end
        OP_ZERO: begin
          res  <= '0;
          clip <= 1'b0;
        end
        OP_MUL: begin
          ma    <= op_a;
          mb    <= op_b;
          ms    <= cmd.msel;
          acc   <= '0;
          mph   <= '0;
          mbusy <= 1'b1;
          mdone <= 1'b0;
        end
        OP_SAT: begin
          res  <= (mres[63:32] != '0) ? '1 : mres[31:0];
          clip <= (mres[63:32] != '0);
        end
        OP_NORM_INIT: begin
          m <= {1'b0, x, 31'b0};
          p <= 5'd31;
          f <= '0;
        end
        OP_NORM_STEP: begin
          m <= {m[62:0], 1'b0};
          p <= p - 5'd1;
        end
        OP_LOG_STEP: begin
          f <= {f[28:0], mres[63]};
          m <= mres[63] ? {1'b0, mres[63:1]} : mres;
        end
        OP_LOG_DONE: begin
          neg <= (p < 5'(PosFrac));
          mag <= (p < 5'(PosFrac)) ? ({1'b0, kk, 30'b0} - {6'b0, f}) : {1'b0, pm, f};
        end
        OP_EXP_SPLIT: begin
          if (neg && fval != '0) begin
            ie <= -$signed({2'b0, ival}) - 11'sd1;
            fr <= 30'((31'h4000_0000) - {1'b0, fval});
          end else if (neg) begin
            ie <= -$signed({2'b0, ival});
            fr <= fval;
          end else begin
            ie <= $signed({2'b0, ival});
            fr <= fval;
          end
        end
        OP_SERIES_INIT: begin
          u    <= mres;
          term <= Q62_ONE;
          sum  <= Q62_ONE;
          idx  <= 5'd1;
        end
        OP_DIV: begin
          dq    <= mres;
          drem  <= '0;
          dcnt  <= '0;
          dbusy <= 1'b1;
          ddone <= 1'b0;
        end
        OP_TERM_ACC: begin
          term <= dq;
          sum  <= sum + dq;
          idx  <= idx + 5'd1;
        end
        OP_POW_DONE: begin
          res  <= {3'b0, 29'(x[28:0] + frac)};
          clip <= 1'b0;
        end
        OP_ROT_INIT: begin
          a  <= nonlinearity;
          rx <= (x >= TWOPI_POS) ? (x - TWOPI_POS) : x;
        end
        OP_ROT_RED: begin
          a <= a - TWOPI_PAR;
        end
        OP_ROT_SUM: begin
          res  <= (rsum >= {1'b0, TWOPI_POS}) ? 32'(rsum - {1'b0, TWOPI_POS}) : rsum[31:0];
          clip <= 1'b0;
        end
        OP_WRITE: begin
          x        <= res;
          position <= pos_hold;
          clipped  <= clip;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts.x_gt_one  = (x > POS_ONE);
    sts.x_lt_half = (x < POS_HALF);
    sts.x_zero    = (x == '0);
    sts.norm_done = m[62];
    sts.a_ge      = (a >= TWOPI_PAR);
    sts.term_last = (idx == 5'(Terms));
    sts.mul_done  = mdone;
    sts.div_done  = ddone;
  end

endmodule

FILE: rtl/cmi_controller.sv
// ----------------------------------------------------------------------------
// Chaotic map iterator controller
// Sequences the datapath through the steps of the selected map and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module cmi_controller import cmi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] map_kind,
  input  status_t    sts,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_MWAIT,
    S_L2,
    S_SAT,
    S_NORM,
    S_LMUL,
    S_LOGS,
    S_LOGD,
    S_ZMUL,
    S_SPLIT,
    S_TMUL,
    S_SER,
    S_UMUL,
    S_DSTART,
    S_DWAIT,
    S_ACC,
    S_PDONE,
    S_ROT,
    S_WRITE
  } state_t;

  state_t     state;
  state_t     ret;
  logic [4:0] lcnt;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.msel = MS_X_CX;
    case (state)
      S_IDLE: if (in_valid) cmd.op = OP_LOAD;
      S_DISPATCH: begin
        case (map_kind)
          MAP_LOGISTIC: begin
            if (sts.x_gt_one) begin
              cmd.op = OP_ZERO_CLIP;
            end else begin
              cmd.op   = OP_MUL;
              cmd.msel = MS_X_CX;
            end
          end
          MAP_TENT: begin
            if (sts.x_lt_half) begin
              cmd.op   = OP_MUL;
              cmd.msel = MS_X_PAR;
            end else if (sts.x_gt_one) begin
              cmd.op = OP_ZERO_CLIP;
            end else begin
              cmd.op   = OP_MUL;
              cmd.msel = MS_CX_PAR;
            end
          end
          MAP_POWER:  cmd.op = sts.x_zero ? OP_ZERO : OP_NORM_INIT;
          default:    cmd.op = OP_ROT_INIT;
        endcase
      end
      S_L2: begin
        cmd.op   = OP_MUL;
        cmd.msel = MS_R_PAR;
      end
      S_SAT:   cmd.op = OP_SAT;
      S_NORM:  if (!sts.norm_done) cmd.op = OP_NORM_STEP;
      S_LMUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = MS_M_M;
      end
      S_LOGS:  cmd.op = OP_LOG_STEP;
      S_LOGD:  cmd.op = OP_LOG_DONE;
      S_ZMUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = MS_MAG_Z;
      end
      S_SPLIT: cmd.op = OP_EXP_SPLIT;
      S_TMUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = MS_T_LN2;
      end
      S_SER:   cmd.op = OP_SERIES_INIT;
      S_UMUL: begin
        cmd.op   = OP_MUL;
        cmd.msel = MS_TERM_U;
      end
      S_DSTART: cmd.op = OP_DIV;
      S_ACC:    cmd.op = OP_TERM_ACC;
      S_PDONE:  cmd.op = OP_POW_DONE;
      S_ROT:    cmd.op = sts.a_ge ? OP_ROT_RED : OP_ROT_SUM;
      S_WRITE:  if (out_free) cmd.op = OP_WRITE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      lcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && state != S_WRITE) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_DISPATCH;
        S_DISPATCH: begin
          case (map_kind)
            MAP_LOGISTIC: begin
              if (sts.x_gt_one) begin
                state <= S_WRITE;
              end else begin
                ret   <= S_L2;
                state <= S_MWAIT;
              end
            end
            MAP_TENT: begin
              if (!sts.x_lt_half && sts.x_gt_one) begin
                state <= S_WRITE;
              end else begin
                ret   <= S_SAT;
                state <= S_MWAIT;
              end
            end
            MAP_POWER: begin
              lcnt  <= '0;
              state <= sts.x_zero ? S_WRITE : S_NORM;
            end
            default: state <= S_ROT;
          endcase
        end
        S_MWAIT: if (sts.mul_done) state <= ret;
        S_L2: begin
          ret   <= S_SAT;
          state <= S_MWAIT;
        end
        S_SAT:  state <= S_WRITE;
        S_NORM: if (sts.norm_done) state <= S_LMUL;
        S_LMUL: begin
          ret   <= S_LOGS;
          state <= S_MWAIT;
        end
        S_LOGS: begin
          if (lcnt == 5'(LogFrac - 1)) begin
            state <= S_LOGD;
          end else begin
            lcnt  <= lcnt + 5'd1;
            state <= S_LMUL;
          end
        end
        S_LOGD: state <= S_ZMUL;
        S_ZMUL: begin
          ret   <= S_SPLIT;
          state <= S_MWAIT;
        end
        S_SPLIT: state <= S_TMUL;
        S_TMUL: begin
          ret   <= S_SER;
          state <= S_MWAIT;
        end
        S_SER: state <= S_UMUL;
        S_UMUL: begin
          ret   <= S_DSTART;
          state <= S_MWAIT;
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT:  if (sts.div_done) state <= S_ACC;
        S_ACC:    state <= sts.term_last ? S_PDONE : S_UMUL;
        S_PDONE:  state <= S_WRITE;
        S_ROT:    if (!sts.a_ge) state <= S_WRITE;
        S_WRITE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/chaotic_map_iterator.sv
// ----------------------------------------------------------------------------
// Chaotic map iterator
// Holds one position and advances it by the selected chaotic map per word.
// ----------------------------------------------------------------------------
// The Pomeau-Manneville map takes up to 31 normalize steps, 30 squarings and
// 20 series terms. One word is in work at a time, and the next can be taken
// as soon as the result is posted; the shared 32x32 multiplier and the serial
// divider do the arithmetic. Synchronous reset clears the held position, the
// configuration registers and the control state, but not the output word.
module chaotic_map_iterator import cmi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] position,
  output logic        clipped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [1:0]  map_kind;
  logic [31:0] nonlinearity;
  logic [31:0] start_position;
  cmd_t        cmd;
  status_t     sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_kind       <= MAP_LOGISTIC;
      nonlinearity   <= '0;
      start_position <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAP_KIND: map_kind       <= cfg_data[1:0];
        REG_NONLIN:   nonlinearity   <= cfg_data;
        REG_START:    start_position <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cmi_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .map_kind  (map_kind),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  cmi_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .restart        (restart),
    .nonlinearity   (nonlinearity),
    .start_position (start_position),
    .sts            (sts),
    .position       (position),
    .clipped        (clipped)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in work");

  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result posted while the sequencer is busy");

  a_write_only_idle_out: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_WRITE |-> !out_valid || out_ready)
    else $error("output word overwritten before it was taken");

endmodule

FILE: sim/chaotic_map_iterator_tb.sv
// ----------------------------------------------------------------------------
// Chaotic map iterator testbench
// Drives words, some with restart set, through every map under many register
// settings, with random idling on both sides, and checks each position and clip
// flag against an in-bench model of the four maps.
// ----------------------------------------------------------------------------
module chaotic_map_iterator_tb;
  import cmi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [63:0] FRAC_MASK = 64'h1FFF_FFFF;
  localparam logic [63:0] POS_MAX = 64'hFFFF_FFFF;

  typedef struct {
    logic [31:0] pos;
    logic clip;
  } step_result_t;

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  class map_scoreboard;
    logic [1:0] map_kind;
    logic [31:0] nonlin;
    logic [31:0] start_pos;
    logic [31:0] cur_pos;
    step_result_t expected_q[$];

    function new();
      map_kind = MAP_LOGISTIC;
      nonlin = '0;
      start_pos = '0;
      cur_pos = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_MAP_KIND: map_kind = data[1:0];
        REG_NONLIN: nonlin = data;
        REG_START: start_pos = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] power_frac(logic [63:0] x, logic [63:0] z);
      int p;
      logic [63:0] m, f, mag, emag, frac, t, u, term, sum;
      longint ilog, lg, ipart, sh;
      bit neg;
      p = 63;
      while (!x[p]) p--;
      m = (p <= 62) ? (x << (62 - p)) : (x >> 1);
      ilog = p - PosFrac;
      f = 0;
      for (int i = 0; i < LogFrac; i++) begin
        m = mul_shift(m, m, 62);
        f = f << 1;
        if (m[63]) begin
          f = f | 1;
          m = m >> 1;
        end
      end
      lg = ilog * (longint'(1) << LogFrac) + longint'(f);
      neg = lg < 0;
      mag = neg ? 64'(-lg) : 64'(lg);
      emag = mul_shift(mag, z, ParFrac);
      ipart = longint'(emag >> LogFrac);
      frac = emag & ((64'd1 << LogFrac) - 1);
      if (neg) begin
        ipart = -ipart;
        if (frac != 0) begin
          ipart = ipart - 1;
          frac = (64'd1 << LogFrac) - frac;
        end
      end
      t = frac << (62 - LogFrac);
      u = mul_shift(t, LN2_Q62, 62);
      term = Q62_ONE;
      sum = Q62_ONE;
      for (int i = 1; i <= Terms; i++) begin
        term = mul_shift(term, u, 62) / i;
        sum = sum + term;
      end
      sh = 62 - PosFrac - ipart;
      if (sh >= 64 || sh <= -64) return 0;
      if (sh >= 0) return (sum >> int'(sh)) & FRAC_MASK;
      return (sum << int'(-sh)) & FRAC_MASK;
    endfunction

    function logic [31:0] advance(logic [63:0] x, logic [63:0] par, output logic clip);
      logic [63:0] res, a, s, one;
      one = {32'd0, POS_ONE};
      clip = 0;
      res = 0;
      case (map_kind)
        MAP_LOGISTIC: begin
          if (x > one) begin
            clip = par != 0;
            return 0;
          end
          res = mul_shift(mul_shift(x, one - x, PosFrac), par, ParFrac);
        end
        MAP_TENT: begin
          if (x < {32'd0, POS_HALF}) res = mul_shift(x, par, ParFrac);
          else if (x > one) begin
            clip = par != 0;
            return 0;
          end else res = mul_shift(one - x, par, ParFrac);
        end
        MAP_POWER: begin
          if (x == 0) return 0;
          return 32'(((x & FRAC_MASK) + power_frac(x, par)) & FRAC_MASK);
        end
        default: begin
          a = (par % {32'd0, TWOPI_PAR}) << (PosFrac - ParFrac);
          x = x % {32'd0, TWOPI_POS};
          s = x + a;
          if (s >= {32'd0, TWOPI_POS}) s = s - {32'd0, TWOPI_POS};
          return s[31:0];
        end
      endcase
      if (res > POS_MAX) begin
        clip = 1;
        res = POS_MAX;
      end
      return res[31:0];
    endfunction

    function void note_input(logic restart);
      step_result_t r;
      if (restart) cur_pos = start_pos;
      r.pos = cur_pos;
      cur_pos = advance({32'd0, cur_pos}, {32'd0, nonlin}, r.clip);
      expected_q.push_back(r);
    endfunction

    function bit check(logic [31:0] pos, logic clip, output string msg);
      step_result_t r;
      msg = "";
      if (expected_q.size() == 0) begin
        msg = $sformatf("unexpected word position=%h clipped=%b", pos, clip);
        return 0;
      end
      r = expected_q.pop_front();
      if (pos !== r.pos || clip !== r.clip) begin
        msg = $sformatf("position=%h clipped=%b, expected %h %b", pos, clip, r.pos, r.clip);
        return 0;
      end
      return 1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic restart = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [31:0] position;
  logic clipped;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  map_scoreboard sb = new();
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int settings_run = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;

  chaotic_map_iterator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .position(position), .clipped(clipped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic send_word(logic r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    restart <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_input(r);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic run_phase(logic [1:0] kind, logic [31:0] par, logic [31:0] start, int n,
                           int mode);
    while (sb.pending() != 0) @(negedge clk);
    write_reg(REG_MAP_KIND, {30'd0, kind});
    write_reg(REG_NONLIN, par);
    write_reg(REG_START, start);
    cfg_valid <= 0;
    send_idle_pct = (mode == 1) ? 71 : (mode == 3) ? 9 : 0;
    recv_stall_pct = (mode == 2) ? 71 : (mode == 3) ? 9 : 0;
    for (int i = 0; i < n; i++) send_word(i == 0 || $urandom_range(7) == 0);
    in_valid <= 0;
    settings_run++;
  endtask

  function automatic logic [31:0] pick_par(logic [1:0] kind);
    if ($urandom_range(5) == 0) return $urandom;
    case (kind)
      MAP_LOGISTIC: return $urandom_range(32'h4000_0000);
      MAP_TENT: return $urandom_range(32'h2000_0000);
      MAP_POWER: return $urandom_range(32'h4000_0000, 32'h0800_0000);
      default: return $urandom;
    endcase
  endfunction

  always begin
    @(negedge clk);
    if (hold_req) begin
      out_ready <= 0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 0;
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (!sb.check(position, clipped, msg)) report_mismatch(msg);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [1:0] kind;
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_word(0);
    send_word(1);
    send_word(0);
    in_valid <= 0;
    run_phase(MAP_LOGISTIC, 32'h4000_0000, 32'h0CCC_CCCD, 4, 0);
    run_phase(MAP_LOGISTIC, 32'h4000_0000, 32'hFFFF_FFFF, 2, 1);
    run_phase(MAP_LOGISTIC, 32'h0000_0000, 32'hFFFF_FFFF, 2, 2);
    run_phase(MAP_TENT, 32'hFFFF_FFFF, 32'h0FFF_FFFF, 3, 3);
    run_phase(MAP_TENT, 32'h2000_0000, 32'h1000_0000, 3, 0);
    run_phase(MAP_TENT, 32'h1800_0000, 32'h3000_0000, 2, 0);
    while (sb.pending() != 0) @(negedge clk);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_valid <= 0;
    run_phase(MAP_POWER, 32'h0000_0000, 32'h0800_0000, 2, 0);
    run_phase(MAP_POWER, 32'h1800_0000, 32'h0000_0000, 2, 1);
    run_phase(MAP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 2);
    run_phase(MAP_CIRCLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 0);
    run_phase(MAP_CIRCLE, 32'h0000_0000, 32'h0000_0000, 2, 3);
    for (int ph = 0; words_sent < 1150; ph++) begin
      kind = $urandom_range(3);
      n = (kind == MAP_POWER) ? $urandom_range(12, 4) : $urandom_range(60, 20);
      if (ph == 3) hold_req = 1;
      if (ph % 9 == 4) begin
        while (sb.pending() != 0) @(negedge clk);
        write_reg(REG_UNUSED, $urandom);
      end
      run_phase(kind, pick_par(kind),
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h2000_0000),
                n, ph % 4);
    end
    while (sb.pending() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("%0d words sent, %0d results checked, %0d register settings", words_sent,
             results_seen, settings_run);
    $display("maps covered: logistic, tent, Pomeau-Manneville and circle rotation");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
